/* hdl/rcp_pkg.sv */
// Package for the regularised contact pressure block.
// Holds payload structs, register indexes, widths and the controller command/status types.
package rcp_pkg;

    localparam int NodeCountDefault = 1024;
    localparam int NodeW = 10;
    localparam int DataW = 32;
    localparam int CfgIdxW = 1;

    localparam logic [CfgIdxW-1:0] RegTimeStep = 1'b0;
    localparam logic [CfgIdxW-1:0] RegDimensions = 1'b1;

    localparam logic [DataW-1:0] TimeStepReset = 32'd655;
    localparam logic [1:0] DimensionsReset = 2'd3;

    typedef struct packed {
        logic [NodeW-1:0]        node_index;
        logic                    in_contact;
        logic [DataW-1:0]        time_scale;
        logic signed [DataW-1:0] pressure_x;
        logic signed [DataW-1:0] pressure_y;
        logic signed [DataW-1:0] pressure_z;
    } t_in_item;

    typedef struct packed {
        logic [NodeW-1:0] node_out;
        logic [DataW-1:0] regularised_pressure;
    } t_out_item;

    // Controller to datapath commands
    typedef struct packed {
        logic load;       // capture input item, start store read
        logic clr;        // clearing pass write
        logic sq_step;    // accumulate one squared component
        logic sqrt_init;
        logic sqrt_step;
        logic mul_a;      // old * t
        logic mul_b;      // dt * norm, sum
        logic div_init;
        logic div_step;
        logic finish;     // form result, write store, fill output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic contact;
        logic t_zero;
    } t_sts;

endpackage

/* hdl/regularised_contact_pressure.sv */
// Regularised contact pressure: one node update per transaction.
// Steps: with zero time scale or out of contact the result follows the square and root
// steps; the low-pass step runs all of them (3 square, 32 root, 2 multiply, 65 divide).
// One item at a time: the next item is accepted once the result is registered, later if output stalls.
// Reset: synchronous; a clearing pass over all NODE_COUNT entries zeroes the store
// before the first item is accepted; registers return to dt=655, dimensions=3.
module regularised_contact_pressure import rcp_pkg::*; #(
    parameter int NODE_COUNT = NodeCountDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out_data,
    input  logic               i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_idx,
    input  logic [DataW-1:0]   i_cfg_data
);
    logic [DataW-1:0] r_time_step;
    logic [1:0]       r_dimensions;
    t_cmd             cmd;
    t_sts             sts;
    logic [1:0]       sq_idx;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step  <= TimeStepReset;
            r_dimensions <= DimensionsReset;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegTimeStep:   r_time_step  <= i_cfg_data;
                RegDimensions: r_dimensions <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    rcp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .o_out_valid, .i_out_ready,
        .i_sts(sts), .o_cmd(cmd), .o_sq_idx(sq_idx)
    );

    rcp_datapath #(.NODE_COUNT(NODE_COUNT)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_sq_idx(sq_idx), .i_item(i_in_data),
        .i_time_step(r_time_step), .i_dimensions(r_dimensions),
        .o_sts(sts), .o_result(o_out_data)
    );
endmodule

/* hdl/rcp_datapath.sv */
// Datapath: pressure store, squared-sum, bit-serial square root and divider.
// Depends on rcp_pkg; driven by rcp_ctrl commands.
module rcp_datapath import rcp_pkg::*; #(
    parameter int NODE_COUNT = NodeCountDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [1:0]       i_sq_idx,
    input  t_in_item         i_item,
    input  logic [DataW-1:0] i_time_step,
    input  logic [1:0]       i_dimensions,
    output t_sts             o_sts,
    output t_out_item        o_result
);
    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    logic [DataW-1:0] mem [NODE_COUNT];
    logic [DataW-1:0] r_rd;
    logic [AW:0]      r_clr_addr;
    logic             r_clr_done;

    t_in_item         r_item;
    logic             r_valid_idx;
    logic [63:0]      r_sum;
    logic [63:0]      r_rem;
    logic [32:0]      r_root;
    logic [5:0]       r_sq_cnt;
    logic [64:0]      r_prod;
    logic [64:0]      r_dvd;
    logic [33:0]      r_drem;
    logic [32:0]      r_den;
    logic [DataW-1:0] r_norm;
    t_out_item        r_out;

    logic [DataW-1:0] sel_p;
    logic [DataW-1:0] mag;
    logic [63:0]      trial;
    logic [63:0]      rem_sh;
    logic [33:0]      drem_sh;
    logic [DataW-1:0] res_word;
    logic [AW-1:0]    rd_addr;
    logic             idx_ok;

    assign idx_ok = ({7'd0, i_item.node_index} < 17'(NODE_COUNT));
    assign rd_addr = AW'(i_item.node_index);

    // Pick and rectify the current component
    always_comb begin
        case (i_sq_idx)
            2'd0:    sel_p = r_item.pressure_x;
            2'd1:    sel_p = r_item.pressure_y;
            default: sel_p = r_item.pressure_z;
        endcase
        mag = sel_p[DataW-1] ? (~sel_p + 1'b1) : sel_p;
    end

    // Restoring square root: two radicand bits per step
    assign rem_sh = {r_rem[61:0], r_sum[63:62]};
    assign trial  = {29'd0, r_root, 2'b01};
    assign drem_sh = {r_drem[32:0], r_dvd[64]};

    always_comb begin
        if (r_dvd[64:32] != 33'd0) res_word = '1;
        else                       res_word = r_dvd[31:0];
    end

    // Store: clearing pass, read, write back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.clr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == (AW+1)'(NODE_COUNT - 1)) r_clr_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            mem[r_clr_addr[AW-1:0]] <= '0;
        end else if (i_cmd.finish && r_valid_idx) begin
            mem[AW'(r_item.node_index)] <= r_item.in_contact
                ? (r_item.time_scale == '0 ? r_norm : res_word) : '0;
        end
        if (i_cmd.load) r_rd <= mem[rd_addr];
    end

    // Arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item      <= i_item;
            r_valid_idx <= idx_ok;
            r_sum       <= '0;
        end
        if (i_cmd.sq_step && ({1'b0, i_sq_idx} < {1'b0, i_dimensions}))
            r_sum <= r_sum + 64'(mag) * 64'(mag);
        if (i_cmd.sqrt_init) begin
            r_rem    <= '0;
            r_root   <= '0;
            r_sq_cnt <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_sum    <= {r_sum[61:0], 2'b00};
            r_sq_cnt <= r_sq_cnt + 1'b1;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[31:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[31:0], 1'b0};
            end
            // Capture the root including the bit decided in this last step
            if (r_sq_cnt == 6'd31)
                r_norm <= (rem_sh >= trial) ? {r_root[30:0], 1'b1} : {r_root[30:0], 1'b0};
        end
        if (i_cmd.mul_a) begin
            r_norm <= r_root[31:0];
            r_prod <= 65'((r_valid_idx ? r_rd : 32'd0)) * 65'(r_item.time_scale);
        end
        if (i_cmd.mul_b) begin
            r_dvd <= r_prod + 65'(i_time_step) * 65'(r_norm);
            r_den <= 33'(r_item.time_scale) + 33'(i_time_step);
        end
        if (i_cmd.div_init) begin
            r_drem <= '0;
        end
        // Restoring divide: one quotient bit per step, quotient shifts into r_dvd
        if (i_cmd.div_step) begin
            if (drem_sh >= {1'b0, r_den}) begin
                r_drem <= drem_sh - {1'b0, r_den};
                r_dvd  <= {r_dvd[63:0], 1'b1};
            end else begin
                r_drem <= drem_sh;
                r_dvd  <= {r_dvd[63:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_out.node_out <= r_item.node_index;
            r_out.regularised_pressure <= r_item.in_contact
                ? (r_item.time_scale == '0 ? r_norm : res_word) : '0;
        end
    end

    assign o_sts.clr_done = r_clr_done;
    assign o_sts.contact  = r_item.in_contact;
    assign o_sts.t_zero   = (r_item.time_scale == '0);
    assign o_result       = r_out;
endmodule

/* hdl/rcp_ctrl.sv */
// Controller: sequences clear pass, norm, low-pass step and output handshake.
// Depends on rcp_pkg; drives rcp_datapath.
module rcp_ctrl import rcp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_sts       i_sts,
    output t_cmd       o_cmd,
    output logic [1:0] o_sq_idx
);
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_SQ    = 4'd2;
    localparam logic [3:0] S_SQRT  = 4'd3;
    localparam logic [3:0] S_MULA  = 4'd4;
    localparam logic [3:0] S_MULB  = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_SQRTI = 4'd8;
    localparam logic [3:0] S_DIVI  = 4'd9;

    logic [3:0] r_state, n_state;
    logic [6:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       accept;

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_sq_idx    = r_cnt[1:0];

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = !i_sts.clr_done;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state = S_SQ;
                    n_cnt = '0;
                end
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 7'd2) n_state = S_SQRTI;
            end
            S_SQRTI: begin
                o_cmd.sqrt_init = 1'b1;
                n_cnt = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 7'd31) begin
                    if (!i_sts.contact || i_sts.t_zero) n_state = S_FIN;
                    else n_state = S_MULA;
                end
            end
            S_MULA: begin
                o_cmd.mul_a = 1'b1;
                n_state = S_MULB;
            end
            S_MULB: begin
                o_cmd.mul_b = 1'b1;
                n_state = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == 7'd64) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end
endmodule

/* hdl/rcp_checker.sv */
// Port-level checker for regularised_contact_pressure, bound to the top level.
// Depends on rcp_pkg.
module rcp_checker import rcp_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped while stalled");

    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !$isunknown(o_out_data))
        else $error("result has unknown bits");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while busy");

    a_out_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !i_in_data.in_contact |=> !o_out_valid || !o_in_ready)
        else $error("unexpected result timing");
endmodule

bind regularised_contact_pressure rcp_checker u_rcp_checker (
    .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_in_data,
    .o_out_valid, .i_out_ready, .o_out_data
);

/* bench/testbench.sv */
// Self-checking bench for regularised_contact_pressure: per-node low-pass of the pressure norm.
// Depends on rcp_pkg and the block RTL. Directed table first, then random phases under
// several time step and dimension settings, checked against a local predictor.
module testbench;
    import rcp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NodeTotal = 1024;
    localparam int LongHold = 400;
    localparam int QuietLimit = 5000;
    localparam int PhaseItems = 173;
    localparam int PhaseCount = 6;

    typedef struct packed {
        t_in_item   item;
        logic       has_exp;
        logic [31:0] exp_value;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    t_in_item           i_in_data;
    logic               o_out_valid;
    logic               i_out_ready;
    t_out_item          o_out_data;
    logic               i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_idx;
    logic [DataW-1:0]   i_cfg_data;

    regularised_contact_pressure dut (.*);

    // Predictor state
    logic [31:0] pressure_store [NodeTotal];
    logic [31:0] step_dt;
    logic [1:0]  dim_count;

    t_out_item   expected_updates [$];
    logic [32:0] typed_values [$];   // {has_exp, value}, one per offered item
    int          error_count = 0;
    int          items_in = 0;
    int          updates_out = 0;
    int          quiet_cycles = 0;
    int          long_holds = 0;
    bit          idle_on = 1;
    bit          long_hold_req = 0;

    t_row directed_rows [13] = '{
        '{'{10'd0,    1'b0, 32'd5,          32'sd7,        32'sd0,        32'sd0},
          1'b1, 32'h0},
        '{'{10'd1023, 1'b1, 32'd0,          32'h00010000,  32'h0,         32'h0},
          1'b1, 32'h00010000},
        '{'{10'd5,    1'b1, 32'd0,          32'h00030000,  32'h00040000,  32'h0},
          1'b1, 32'h00050000},
        '{'{10'd7,    1'b1, 32'd0,          32'h80000000,  32'h0,         32'h0},
          1'b1, 32'h80000000},
        '{'{10'd7,    1'b1, 32'd0,          32'h7FFFFFFF,  32'h0,         32'h0},
          1'b1, 32'h7FFFFFFF},
        '{'{10'd6,    1'b1, 32'd0,          32'h80000000,  32'h80000000,  32'h80000000},
          1'b0, 32'h0},
        '{'{10'd6,    1'b1, 32'hFFFFFFFF,   32'h7FFFFFFF,  32'h7FFFFFFF,  32'h7FFFFFFF},
          1'b0, 32'h0},
        '{'{10'd5,    1'b1, 32'd1,          32'h0,         32'h0,         32'h0},
          1'b0, 32'h0},
        '{'{10'd5,    1'b1, 32'h00010000,   32'hFFFF0000,  32'h0,         32'h0},
          1'b0, 32'h0},
        '{'{10'd1023, 1'b0, 32'hFFFFFFFF,   32'h7FFFFFFF,  32'h7FFFFFFF,  32'h7FFFFFFF},
          1'b1, 32'h0},
        '{'{10'd1023, 1'b1, 32'h00020000,   32'h0,         32'hFFFF0000,  32'h0},
          1'b0, 32'h0},
        '{'{10'd512,  1'b1, 32'd0,          32'h0,         32'h0,         32'h0},
          1'b1, 32'h0},
        '{'{10'd7,    1'b1, 32'hFFFFFFFF,   32'h0,         32'h0,         32'hFFFFFFFF},
          1'b0, 32'h0}
    };

    // Clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] probe;
        root = '0;
        probe = 64'd1 << 62;
        while (probe > v) probe = probe >> 2;
        while (probe != 0) begin
            if (v >= root + probe) begin
                v = v - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] square_mag(input logic [31:0] p);
        logic [63:0] m;
        m = {32'd0, (p[31] ? (~p + 32'd1) : p)};
        return m * m;
    endfunction

    // Work out the node's new pressure and update the local store
    function automatic logic [31:0] lowpass_update(input t_in_item it);
        logic [63:0] sum_sq;
        logic [63:0] norm;
        logic [63:0] old_term;
        logic [63:0] new_term;
        logic [64:0] numer;
        logic [32:0] denom;
        logic [64:0] quot;
        logic [31:0] result;
        logic [31:0] old_value;
        old_value = pressure_store[it.node_index];
        if (!it.in_contact) begin
            result = '0;
        end else begin
            sum_sq = '0;
            if (dim_count >= 2'd1) sum_sq = sum_sq + square_mag(it.pressure_x);
            if (dim_count >= 2'd2) sum_sq = sum_sq + square_mag(it.pressure_y);
            if (dim_count >= 2'd3) sum_sq = sum_sq + square_mag(it.pressure_z);
            norm = floor_sqrt(sum_sq);
            if (norm > 64'hFFFFFFFF) norm = 64'hFFFFFFFF;
            if (it.time_scale == '0) begin
                result = norm[31:0];
            end else begin
                old_term = {32'd0, old_value} * {32'd0, it.time_scale};
                new_term = {32'd0, step_dt} * norm;
                numer = {1'b0, old_term} + {1'b0, new_term};
                denom = {1'b0, it.time_scale} + {1'b0, step_dt};
                quot = numer / {32'd0, denom};
                result = (quot > 65'hFFFFFFFF) ? 32'hFFFFFFFF : quot[31:0];
            end
        end
        pressure_store[it.node_index] = result;
        return result;
    endfunction

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Predict on input transactions, check output transactions
    always @(posedge i_clk) begin
        t_out_item  want;
        logic [32:0] typed;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                typed = typed_values.pop_front();
                want.node_out = i_in_data.node_index;
                want.regularised_pressure = lowpass_update(i_in_data);
                if (typed[32]) want.regularised_pressure = typed[31:0];
                expected_updates.push_back(want);
                items_in++;
            end
            if (o_out_valid && i_out_ready) begin
                updates_out++;
                if (expected_updates.size() == 0) begin
                    report("unexpected update", o_out_data.regularised_pressure, 32'h0);
                end else begin
                    want = expected_updates.pop_front();
                    if (o_out_data.node_out != want.node_out)
                        report("node_out", {22'd0, o_out_data.node_out}, {22'd0, want.node_out});
                    if (o_out_data.regularised_pressure != want.regularised_pressure)
                        report("regularised_pressure", o_out_data.regularised_pressure,
                               want.regularised_pressure);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == QuietLimit) begin
                $display("watchdog: no transaction for %0d cycles", QuietLimit);
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver: random stalls, one long hold on request
    initial begin
        int g;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                i_out_ready <= 1'b0;
                repeat (LongHold) @(posedge i_clk);
                long_hold_req = 0;
                long_holds++;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    i_out_ready <= 1'b0;
                    repeat (g) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic send_item(input t_in_item it, input logic has_exp, input logic [31:0] value);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        typed_values.push_back({has_exp, value});
        i_in_data <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == RegTimeStep) step_dt = value;
        else dim_count = value[1:0];
    endtask

    // Hold until every update is back, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_updates.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_pressure();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 32'h0004FFFF);
            2: return -$urandom_range(0, 32'h0004FFFF);
            default: return $urandom_range(0, 1) ? 32'h80000000 : 32'h7FFFFFFF;
        endcase
    endfunction

    function automatic t_in_item rand_item();
        t_in_item it;
        it.node_index = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 15))
                                                   : 10'($urandom_range(0, 1023));
        it.in_contact = ($urandom_range(0, 99) < 85);
        case ($urandom_range(0, 4))
            0: it.time_scale = '0;
            1: it.time_scale = $urandom_range(1, 32'h00040000);
            2: it.time_scale = 32'hFFFFFFFF;
            default: it.time_scale = $urandom();
        endcase
        it.pressure_x = rand_pressure();
        it.pressure_y = rand_pressure();
        it.pressure_z = rand_pressure();
        return it;
    endfunction

    // Stimulus
    initial begin
        logic [31:0] phase_dt [PhaseCount];
        logic [1:0]  phase_dims [PhaseCount];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        for (int n = 0; n < NodeTotal; n++) pressure_store[n] = '0;
        step_dt = TimeStepReset;
        dim_count = DimensionsReset;
        phase_dt = '{TimeStepReset, 32'd0, 32'hFFFFFFFF, 32'd1, $urandom(), 32'h00010000};
        phase_dims = '{DimensionsReset, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed rows under reset settings
        foreach (directed_rows[r])
            send_item(directed_rows[r].item, directed_rows[r].has_exp, directed_rows[r].exp_value);
        drain();

        for (int p = 0; p < PhaseCount; p++) begin
            write_reg(RegTimeStep, phase_dt[p]);
            write_reg(RegDimensions, {30'd0, phase_dims[p]});
            idle_on = (p != 4);
            for (int k = 0; k < PhaseItems; k++) begin
                if (p == 2 && k == 50) long_hold_req = 1;
                send_item(rand_item(), 1'b0, 32'h0);
            end
            drain();
        end

        repeat (150) @(posedge i_clk);
        $display("summary: %0d items, %0d updates, %0d long output holds, %0d config phases",
                 items_in, updates_out, long_holds, PhaseCount);
        $display("summary: dt from 0 to max, dimensions 0..3, zero and full time scales");
        if (error_count == 0 && expected_updates.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
